>>> rtl/assert_macros.svh
// assertion helpers used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled while in reset
`define ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, disabled while in reset
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> rtl/dsae_pkg.sv
package dsae_pkg;

	// storage and field sizes
	localparam int MEM_DEPTH  = 4096;
	localparam int DATA_WIDTH = 32;
	localparam int ADDR_W     = $clog2(MEM_DEPTH);
	localparam int REG_W      = 12;
	localparam int OP_W       = 8;
	localparam int SLOT_W     = 20;
	localparam int INSTR_W    = 2 * SLOT_W;

	// register reset values
	localparam logic [REG_W-1:0] REF_ADDR_RST    = 12'd3;
	localparam logic [REG_W-1:0] START_COUNT_RST = 12'd420;

	// opcodes
	localparam logic [OP_W-1:0] OP_LOAD = 8'b0000_0001;
	localparam logic [OP_W-1:0] OP_STOR = 8'b0010_0001;
	localparam logic [OP_W-1:0] OP_ADD  = 8'b0000_0101;
	localparam logic [OP_W-1:0] OP_LESS = 8'b0000_0111;
	localparam logic [OP_W-1:0] OP_GRET = 8'b0011_1110;

	typedef enum logic [1:0] {
		ACT_WRITE = 2'd0,
		ACT_EXEC  = 2'd1,
		ACT_READ  = 2'd2,
		ACT_NONE  = 2'd3
	} action_t;

	typedef enum logic {
		CFG_REF_ADDR    = 1'b0,
		CFG_START_COUNT = 1'b1
	} cfg_index_t;

	typedef enum logic [2:0] {
		OPK_NONE,
		OPK_LOAD,
		OPK_STOR,
		OPK_ADD,
		OPK_CMP
	} op_kind_t;

	typedef enum logic [2:0] {
		MEM_IDLE,
		MEM_WR_ITEM,
		MEM_RD_ITEM,
		MEM_RD_SLOT,
		MEM_WR_SLOT,
		MEM_RD_PTR,
		MEM_RD_REF
	} mem_op_t;

	typedef enum logic [2:0] {
		UPD_NONE,
		UPD_READ,
		UPD_LOAD,
		UPD_ADD,
		UPD_STOR,
		UPD_VAL,
		UPD_CMP
	} upd_t;

	// controller to datapath
	typedef struct packed {
		logic    load_item;
		logic    right;
		mem_op_t mem_op;
		upd_t    upd;
		logic    count_inc;
	} dsae_cmd_t;

	// opcode decode; compare ops only count in their own slot
	function automatic op_kind_t decode_op(logic [OP_W-1:0] op, logic right);
		op_kind_t k;
		k = OPK_NONE;
		unique case (op)
			OP_LOAD: k = OPK_LOAD;
			OP_STOR: k = OPK_STOR;
			OP_ADD:  k = OPK_ADD;
			OP_LESS: k = right ? OPK_NONE : OPK_CMP;
			OP_GRET: k = right ? OPK_CMP : OPK_NONE;
			default: k = OPK_NONE;
		endcase
		return k;
	endfunction

endpackage

>>> rtl/dual_slot_accumulator_executor.sv
// Accumulator machine that runs one 40-bit instruction pair (left slot, then right slot)
// per execute item, and also takes memory write and read items. An item is taken when
// start is high and busy is low; exactly one result follows, shown for a single cycle
// with done high, and it cannot be held off, so capture it then. Every memory access
// goes through one single-port data RAM with a registered read, so the item time is set
// by how many dependent accesses it needs: a write one RAM write, a read a read and its
// capture, action three done alone, an execute slot one step (STOR, no-op), a read and
// an update (LOAD, ADD) or reads of slot word, pointer and reference (LESS, GRET). busy
// drops in the done cycle, so a new item may start then. Configuration must be written
// only while idle (not enforced); writing start_count also presets the program counter.
module dual_slot_accumulator_executor (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   start,
	output logic                                   busy,
	output logic                                   done,
	input  logic [1:0]                             action,
	input  logic [dsae_pkg::REG_W-1:0]             address,
	input  logic signed [dsae_pkg::DATA_WIDTH-1:0] write_value,
	input  logic [dsae_pkg::INSTR_W-1:0]           instruction_word,
	output logic signed [dsae_pkg::DATA_WIDTH-1:0] accumulator,
	output logic signed [dsae_pkg::DATA_WIDTH-1:0] buffer_value,
	output logic [dsae_pkg::REG_W-1:0]             program_count,
	output logic signed [dsae_pkg::DATA_WIDTH-1:0] read_value,
	input  logic                                   cfg_write,
	input  logic                                   cfg_index,
	input  logic [dsae_pkg::REG_W-1:0]             cfg_data
);

	dsae_pkg::dsae_cmd_t                cmd;
	dsae_pkg::op_kind_t                 op;
	logic [dsae_pkg::DATA_WIDTH-1:0]    acc, buf_val, rd_val;

	// sequencing
	dsae_ctrl u_ctrl (
		.clk   (clk),
		.arst_n(arst_n),
		.start (start),
		.action(action),
		.op    (op),
		.busy  (busy),
		.done  (done),
		.cmd   (cmd)
	);

	// registers, memory and arithmetic
	dsae_dpath u_dpath (
		.clk             (clk),
		.arst_n          (arst_n),
		.cmd             (cmd),
		.address         (address),
		.write_value     (write_value),
		.instruction_word(instruction_word),
		.cfg_write       (cfg_write),
		.cfg_index       (cfg_index),
		.cfg_data        (cfg_data),
		.op              (op),
		.acc             (acc),
		.buf_val         (buf_val),
		.count           (program_count),
		.rd_val          (rd_val)
	);

	assign accumulator  = acc;
	assign buffer_value = buf_val;
	assign read_value   = rd_val;

endmodule

>>> rtl/dsae_ram.sv
module dsae_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 4096
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] addr,
	input  logic [WIDTH-1:0]         wdata,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// single port, registered read
	always_ff @(posedge clk) begin
		if (we) begin
			mem[addr] <= wdata;
		end
		rdata <= mem[addr];
	end

endmodule

>>> rtl/dsae_ctrl.sv
module dsae_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	input  logic [1:0]          action,
	input  dsae_pkg::op_kind_t  op,
	output logic                busy,
	output logic                done,
	output dsae_pkg::dsae_cmd_t cmd
);

	typedef enum logic [3:0] {
		S_IDLE,
		S_WRITE,
		S_READ,
		S_READ_CAP,
		S_SLOT,
		S_LOAD,
		S_ADD,
		S_PTR,
		S_VAL,
		S_CMP
	} state_t;

	state_t state_q, state_d;
	logic   right_q;
	logic   done_q, done_d;
	logic   slot_end;

	// command decode and next state
	always_comb begin
		cmd           = '0;
		cmd.right     = right_q;
		cmd.mem_op    = dsae_pkg::MEM_IDLE;
		cmd.upd       = dsae_pkg::UPD_NONE;
		slot_end      = 1'b0;
		state_d       = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (start) begin
					cmd.load_item = 1'b1;
					unique case (dsae_pkg::action_t'(action))
						dsae_pkg::ACT_WRITE: state_d = S_WRITE;
						dsae_pkg::ACT_EXEC:  state_d = S_SLOT;
						dsae_pkg::ACT_READ:  state_d = S_READ;
						dsae_pkg::ACT_NONE:  state_d = S_IDLE;
						default:             state_d = S_IDLE;
					endcase
				end
			end
			S_WRITE: begin
				cmd.mem_op = dsae_pkg::MEM_WR_ITEM;
				state_d    = S_IDLE;
			end
			S_READ: begin
				cmd.mem_op = dsae_pkg::MEM_RD_ITEM;
				state_d    = S_READ_CAP;
			end
			S_READ_CAP: begin
				cmd.upd = dsae_pkg::UPD_READ;
				state_d = S_IDLE;
			end
			S_SLOT: begin
				unique case (op)
					dsae_pkg::OPK_LOAD: begin
						cmd.mem_op = dsae_pkg::MEM_RD_SLOT;
						state_d    = S_LOAD;
					end
					dsae_pkg::OPK_ADD: begin
						cmd.mem_op = dsae_pkg::MEM_RD_SLOT;
						state_d    = S_ADD;
					end
					dsae_pkg::OPK_CMP: begin
						cmd.mem_op = dsae_pkg::MEM_RD_SLOT;
						state_d    = S_PTR;
					end
					dsae_pkg::OPK_STOR: begin
						cmd.mem_op = dsae_pkg::MEM_WR_SLOT;
						cmd.upd    = dsae_pkg::UPD_STOR;
						slot_end   = 1'b1;
					end
					default: slot_end = 1'b1;
				endcase
			end
			S_LOAD: begin
				cmd.upd  = dsae_pkg::UPD_LOAD;
				slot_end = 1'b1;
			end
			S_ADD: begin
				cmd.upd  = dsae_pkg::UPD_ADD;
				slot_end = 1'b1;
			end
			S_PTR: begin
				cmd.mem_op = dsae_pkg::MEM_RD_PTR;
				state_d    = S_VAL;
			end
			S_VAL: begin
				cmd.upd    = dsae_pkg::UPD_VAL;
				cmd.mem_op = dsae_pkg::MEM_RD_REF;
				state_d    = S_CMP;
			end
			S_CMP: begin
				cmd.upd  = dsae_pkg::UPD_CMP;
				slot_end = 1'b1;
			end
			default: state_d = S_IDLE;
		endcase

		// left slot hands over to the right one, bumping the counter
		if (slot_end) begin
			if (!right_q) begin
				cmd.count_inc = 1'b1;
				state_d       = S_SLOT;
			end else begin
				state_d = S_IDLE;
			end
		end

		done_d = (state_d == S_IDLE) && ((state_q != S_IDLE) || cmd.load_item);
	end

	// state and registered outputs
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			right_q <= 1'b0;
			done_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			done_q  <= done_d;
			if (cmd.load_item) begin
				right_q <= 1'b0;
			end else if (slot_end && !right_q) begin
				right_q <= 1'b1;
			end
		end
	end

	assign busy = (state_q != S_IDLE);
	assign done = done_q;

endmodule

>>> rtl/dsae_dpath.sv
module dsae_dpath (
	input  logic                                     clk,
	input  logic                                     arst_n,
	input  dsae_pkg::dsae_cmd_t                      cmd,
	input  logic [dsae_pkg::REG_W-1:0]               address,
	input  logic signed [dsae_pkg::DATA_WIDTH-1:0]   write_value,
	input  logic [dsae_pkg::INSTR_W-1:0]             instruction_word,
	input  logic                                     cfg_write,
	input  logic                                     cfg_index,
	input  logic [dsae_pkg::REG_W-1:0]               cfg_data,
	output dsae_pkg::op_kind_t                       op,
	output logic [dsae_pkg::DATA_WIDTH-1:0]          acc,
	output logic [dsae_pkg::DATA_WIDTH-1:0]          buf_val,
	output logic [dsae_pkg::REG_W-1:0]               count,
	output logic [dsae_pkg::DATA_WIDTH-1:0]          rd_val
);

	localparam int AW = dsae_pkg::ADDR_W;
	localparam int DW = dsae_pkg::DATA_WIDTH;
	localparam int RW = dsae_pkg::REG_W;
	localparam int SW = dsae_pkg::SLOT_W;
	localparam int OW = dsae_pkg::OP_W;

	logic [RW-1:0]                    addr_q;
	logic [DW-1:0]                    wval_q;
	logic [dsae_pkg::INSTR_W-1:0]     iw_q;
	logic [DW-1:0]                    acc_q, buf_q, rd_q, v_q;
	logic [RW-1:0]                    count_q, ref_q;

	logic [OW-1:0]                    slot_op;
	logic [RW-1:0]                    slot_addr;
	logic                             ram_we;
	logic [AW-1:0]                    ram_addr;
	logic [DW-1:0]                    ram_wdata, ram_rdata;

	// current slot fields
	assign slot_op   = cmd.right ? iw_q[RW +: OW] : iw_q[2*SW-OW +: OW];
	assign slot_addr = cmd.right ? iw_q[RW-1:0] : iw_q[SW +: RW];
	assign op        = dsae_pkg::decode_op(slot_op, cmd.right);

	// memory port select
	always_comb begin
		ram_we    = 1'b0;
		ram_wdata = acc_q;
		ram_addr  = slot_addr[AW-1:0];
		unique case (cmd.mem_op)
			dsae_pkg::MEM_WR_ITEM: begin
				ram_we    = 1'b1;
				ram_wdata = wval_q;
				ram_addr  = addr_q[AW-1:0];
			end
			dsae_pkg::MEM_RD_ITEM: ram_addr = addr_q[AW-1:0];
			dsae_pkg::MEM_WR_SLOT: ram_we   = 1'b1;
			dsae_pkg::MEM_RD_PTR:  ram_addr = ram_rdata[AW-1:0];
			dsae_pkg::MEM_RD_REF:  ram_addr = ref_q[AW-1:0];
			default:               ram_addr = slot_addr[AW-1:0];
		endcase
	end

	dsae_ram #(
		.WIDTH(DW),
		.DEPTH(dsae_pkg::MEM_DEPTH)
	) u_ram (
		.clk  (clk),
		.we   (ram_we),
		.addr (ram_addr),
		.wdata(ram_wdata),
		.rdata(ram_rdata)
	);

	// item capture and indirect value
	always_ff @(posedge clk) begin
		if (cmd.load_item) begin
			addr_q <= address;
			wval_q <= write_value;
			iw_q   <= instruction_word;
		end
		if (cmd.upd == dsae_pkg::UPD_VAL) begin
			v_q <= ram_rdata;
		end
	end

	// architectural registers and configuration
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q   <= '0;
			buf_q   <= '0;
			rd_q    <= '0;
			count_q <= dsae_pkg::START_COUNT_RST;
			ref_q   <= dsae_pkg::REF_ADDR_RST;
		end else begin
			if (cfg_write) begin
				unique case (dsae_pkg::cfg_index_t'(cfg_index))
					dsae_pkg::CFG_REF_ADDR:    ref_q   <= cfg_data;
					dsae_pkg::CFG_START_COUNT: count_q <= cfg_data;
					default:                   ref_q   <= ref_q;
				endcase
			end else if (cmd.count_inc) begin
				count_q <= count_q + RW'(1);
			end

			if (cmd.load_item) begin
				rd_q <= '0;
			end

			case (cmd.upd)
				dsae_pkg::UPD_READ: rd_q <= ram_rdata;
				dsae_pkg::UPD_LOAD: begin
					acc_q <= ram_rdata;
					buf_q <= ram_rdata;
				end
				dsae_pkg::UPD_ADD: begin
					acc_q <= acc_q + ram_rdata;
					buf_q <= ram_rdata;
				end
				dsae_pkg::UPD_STOR: buf_q <= acc_q;
				dsae_pkg::UPD_CMP: begin
					// left slot: take reference when below it; right: take value when above
					if (!cmd.right && ($signed(v_q) < $signed(ram_rdata))) begin
						acc_q <= ram_rdata;
						buf_q <= ram_rdata;
					end else if (cmd.right && ($signed(v_q) > $signed(ram_rdata))) begin
						acc_q <= v_q;
						buf_q <= v_q;
					end
				end
				default: acc_q <= acc_q;
			endcase
		end
	end

	assign acc     = acc_q;
	assign buf_val = buf_q;
	assign count   = count_q;
	assign rd_val  = rd_q;

endmodule

>>> rtl/dsae_checker.sv
`include "assert_macros.svh"

module dsae_checker (
	input logic                                   clk,
	input logic                                   arst_n,
	input logic                                   start,
	input logic                                   busy,
	input logic                                   done,
	input logic                                   cfg_write,
	input logic                                   cfg_index,
	input logic [dsae_pkg::REG_W-1:0]             cfg_data,
	input logic signed [dsae_pkg::DATA_WIDTH-1:0] accumulator,
	input logic [dsae_pkg::REG_W-1:0]             program_count
);

	// a result only appears once the block is free again
	`ASSERT_SAME(a_done_not_busy, clk, arst_n, done, !busy, "done while busy")

	// an accepted transfer either occupies the block or finishes at once
	`ASSERT_NEXT(a_accept_progress, clk, arst_n, start && !busy, busy || done,
		"accepted item left no trace")

	// one result per item: no second strobe without a new transfer
	`ASSERT_NEXT(a_single_done, clk, arst_n, done && !start, !done, "repeated result strobe")

	// idle without a transfer leaves the accumulator alone
	`ASSERT_NEXT(a_idle_acc_stable, clk, arst_n, !busy && !start, $stable(accumulator),
		"accumulator moved while idle")

	// counter preset takes effect on the next cycle
	`ASSERT_NEXT(a_count_preset, clk, arst_n,
		cfg_write && (cfg_index == dsae_pkg::CFG_START_COUNT) && !busy,
		program_count == $past(cfg_data), "program counter preset lost")

endmodule

bind dual_slot_accumulator_executor dsae_checker u_dsae_checker (.*);
